[hdl/seven_segment_display_controller_top_defines.svh]
// Assertion macros for the display controller.
`ifndef SEVEN_SEGMENT_DISPLAY_CONTROLLER_TOP_DEFINES_SVH
`define SEVEN_SEGMENT_DISPLAY_CONTROLLER_TOP_DEFINES_SVH

// Checked on every rising edge of clk, off while reset is asserted.
`define SSD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define SSD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/ssd_pkg.sv]
`timescale 1ns / 1ps

package ssd_pkg;

	localparam int NUM_DIGITS = 4;
	localparam int SCAN_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int MAG_W      = 17;
	localparam int BCD_DIGITS = (NUM_DIGITS > 6) ? NUM_DIGITS : 6;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int CNT_W      = $clog2(MAG_W + 1);
	localparam int EXT_W      = 4 * NUM_DIGITS + MAG_W;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [6:0] SEG_MINUS  = 7'h40;

	typedef enum logic [2:0] {
		CMD_TICK    = 3'd0,
		CMD_DECIMAL = 3'd1,
		CMD_HEX     = 3'd2,
		CMD_CHARS   = 3'd3,
		CMD_BINARY  = 3'd4,
		CMD_DIGIT   = 3'd5
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_CONV
	} state_t;

	typedef struct packed {
		logic             done;
		logic [BCD_W-1:0] digits;
	} bcd_status_t;

	function automatic logic [6:0] hex_glyph(input logic [3:0] v);
		logic [6:0] g;
		case (v)
			4'h0: g = 7'h3F;
			4'h1: g = 7'h06;
			4'h2: g = 7'h5B;
			4'h3: g = 7'h4F;
			4'h4: g = 7'h66;
			4'h5: g = 7'h6D;
			4'h6: g = 7'h7D;
			4'h7: g = 7'h07;
			4'h8: g = 7'h7F;
			4'h9: g = 7'h6F;
			4'hA: g = 7'h77;
			4'hB: g = 7'h7C;
			4'hC: g = 7'h39;
			4'hD: g = 7'h5E;
			4'hE: g = 7'h79;
			4'hF: g = 7'h71;
			default: g = 7'h00;
		endcase
		return g;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [7:0] c;
		if (v < 4'd10) begin
			c = CHAR_ZERO + {4'h0, v};
		end else begin
			c = CHAR_UA + {4'h0, v - 4'd10};
		end
		return c;
	endfunction

	function automatic logic [6:0] glyph_of(input logic [7:0] c);
		logic [6:0] g;
		if (c >= 8'h30 && c <= 8'h39) begin
			g = hex_glyph(c[3:0]);
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			g = hex_glyph(c[3:0] + 4'd9);
		end else if (c == CHAR_MINUS) begin
			g = SEG_MINUS;
		end else begin
			g = 7'h00;
		end
		return g;
	endfunction

endpackage

[hdl/ssd_bcd.sv]
`timescale 1ns / 1ps

module ssd_bcd (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ssd_pkg::MAG_W-1:0]  value,
	output ssd_pkg::bcd_status_t       status
);
	import ssd_pkg::*;

	logic [MAG_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] adj;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	// add-3 correction ahead of each shift
	always_comb begin
		adj = bcd_q;
		for (int d = 0; d < BCD_DIGITS; d++) begin
			if (bcd_q[4*d +: 4] >= 4'd5) begin
				adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(MAG_W);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				run_q <= (cnt_q != CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (run_q) begin
			bin_q <= {bin_q[MAG_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[MAG_W-1]};
		end
	end

	assign status.done   = done_q;
	assign status.digits = bcd_q;

endmodule

[hdl/seven_segment_display_controller_top.sv]
`timescale 1ns / 1ps
// Channel   | Handshake                 | Fields
// ----------+---------------------------+----------------------------------------------
// command   | start && !busy            | command, number, point_position,
//           |                           | digit_position, char_first .. char_fourth
// result    | strobe (one cycle)        | segments, digit_enables
//
// Set decimal keeps busy high after its accept, through 17 shift-and-correct steps of
// the binary-to-BCD unit and the digit load.
// All other commands leave busy low; a tick's result shows on the next cycle.
// arst_n clears the display to spaces, points and binary mode off, scan at 0.
// Results cannot be held off; each is valid only while strobe is high.
`include "seven_segment_display_controller_top_defines.svh"

module seven_segment_display_controller_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         command,
	input  logic signed [16:0] number,
	input  logic [3:0]         point_position,
	input  logic [2:0]         digit_position,
	input  logic [7:0]         char_first,
	input  logic [7:0]         char_second,
	input  logic [7:0]         char_third,
	input  logic [7:0]         char_fourth,
	output logic               strobe,
	output logic [7:0]         segments,
	output logic [3:0]         digit_enables
);
	import ssd_pkg::*;

	state_t            state_q;
	state_t            state_d;
	cmd_t              cmd;
	logic              accept;
	logic              bcd_start;
	logic              load_digits;
	bcd_status_t       bcd_status;

	logic [7:0]        digit_chars_q [NUM_DIGITS];
	logic [NUM_DIGITS-1:0] point_q;
	logic              binary_q;
	logic [7:0]        binary_byte_q;
	logic [SCAN_W-1:0] scan_q;
	logic              neg_q;

	logic              strobe_q;
	logic [7:0]        segments_q;
	logic [3:0]        enables_q;

	logic [MAG_W-1:0]  mag;
	logic [EXT_W-1:0]  num_ext;
	logic [NUM_DIGITS-1:0] point_d;
	logic [BCD_DIGITS-1:0] nz;
	logic [7:0]        dec_chars [NUM_DIGITS];
	logic [7:0]        chars_in [4];
	logic [3:0]        tick_en;

	assign cmd     = cmd_t'(command);
	assign accept  = start && !busy;
	assign mag     = number[16] ? (~number + 17'd1) : number;
	assign num_ext = {{(EXT_W-MAG_W){number[16]}}, number};
	assign chars_in[0] = char_first;
	assign chars_in[1] = char_second;
	assign chars_in[2] = char_third;
	assign chars_in[3] = char_fourth;

	ssd_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.value  (mag),
		.status (bcd_status)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd == CMD_DECIMAL) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (bcd_status.done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy        = 1'b0;
		bcd_start   = 1'b0;
		load_digits = 1'b0;
		case (state_q)
			ST_IDLE: begin
				bcd_start = accept && cmd == CMD_DECIMAL;
			end
			ST_CONV: begin
				busy        = 1'b1;
				load_digits = bcd_status.done;
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int j = 0; j < NUM_DIGITS; j++) begin
			point_d[j] = (int'(point_position) == j + 1);
		end
	end

	// nonzero at or above each decimal place
	always_comb begin
		nz = '0;
		for (int k = BCD_DIGITS - 1; k >= 0; k--) begin
			if (k == BCD_DIGITS - 1) begin
				nz[k] = |bcd_status.digits[4*k +: 4];
			end else begin
				nz[k] = nz[k+1] | (|bcd_status.digits[4*k +: 4]);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (i == NUM_DIGITS - 1 || nz[NUM_DIGITS-1-i]) begin
				dec_chars[i] = CHAR_ZERO + {4'h0, bcd_status.digits[4*(NUM_DIGITS-1-i) +: 4]};
			end else if (i == 0 && neg_q) begin
				dec_chars[i] = CHAR_MINUS;
			end else begin
				dec_chars[i] = CHAR_SPACE;
			end
		end
	end

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			tick_en[b] = (int'(scan_q) != b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			point_q       <= '0;
			binary_q      <= 1'b0;
			binary_byte_q <= '0;
			scan_q        <= '0;
			strobe_q      <= 1'b0;
			for (int i = 0; i < NUM_DIGITS; i++) begin
				digit_chars_q[i] <= CHAR_SPACE;
			end
		end else begin
			state_q  <= state_d;
			strobe_q <= accept && cmd == CMD_TICK;
			if (load_digits) begin
				for (int i = 0; i < NUM_DIGITS; i++) begin
					digit_chars_q[i] <= dec_chars[i];
				end
			end else if (accept) begin
				case (cmd)
					CMD_TICK: begin
						if (!binary_q) begin
							scan_q <= (scan_q == SCAN_W'(NUM_DIGITS - 1)) ? '0
							          : scan_q + SCAN_W'(1);
						end
					end
					CMD_DECIMAL: begin
						binary_q <= 1'b0;
						point_q  <= point_d;
					end
					CMD_HEX: begin
						binary_q <= 1'b0;
						point_q  <= '0;
						for (int i = 0; i < NUM_DIGITS; i++) begin
							digit_chars_q[i] <= hex_char(num_ext[4*(NUM_DIGITS-1-i) +: 4]);
						end
					end
					CMD_CHARS: begin
						binary_q <= 1'b0;
						point_q  <= '0;
						for (int i = 0; i < NUM_DIGITS; i++) begin
							digit_chars_q[i] <= (i < 4) ? chars_in[i] : CHAR_SPACE;
						end
					end
					CMD_BINARY: begin
						binary_q      <= 1'b1;
						binary_byte_q <= number[7:0];
					end
					CMD_DIGIT: begin
						binary_q <= 1'b0;
						point_q  <= point_d;
						for (int i = 0; i < NUM_DIGITS; i++) begin
							if (int'(digit_position) == i + 1) begin
								if (!number[16] && number[15:0] <= 16'd15) begin
									digit_chars_q[i] <= hex_char(number[3:0]);
								end else if (!number[16] && number[15:0] == 16'(CHAR_MINUS)) begin
									digit_chars_q[i] <= CHAR_MINUS;
								end
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bcd_start) begin
			neg_q <= number[16];
		end
		if (accept && cmd == CMD_TICK) begin
			if (binary_q) begin
				segments_q <= binary_byte_q;
				enables_q  <= 4'hF;
			end else begin
				segments_q <= {point_q[scan_q], glyph_of(digit_chars_q[scan_q])};
				enables_q  <= tick_en;
			end
		end
	end

	assign strobe        = strobe_q;
	assign segments      = segments_q;
	assign digit_enables = enables_q;

	`SSD_ASSERT(a_strobe_from_tick, strobe |-> $past(start && !busy && command == CMD_TICK), "result without tick")
	`SSD_ASSERT(a_busy_from_decimal, $rose(busy) |-> $past(start && command == CMD_DECIMAL), "busy without decimal")
	`SSD_ASSERT(a_one_digit_on, (strobe && digit_enables != 4'hF) |-> $onehot(~digit_enables), "multiple digits on")
	`SSD_ASSERT_ALWAYS(a_no_strobe_busy, !(strobe && busy), "result during conversion")

endmodule
